@@ rtl/pkf_pkg.sv @@
// Shared types and constants for the six-axis pose Kalman filter.
package pkf_pkg;

   // Fixed-point format and gain format
   localparam int FRAC_BITS  = 16;
   localparam int GAIN_BITS  = 17;
   localparam int GAIN_FRAC  = 16;
   localparam logic [GAIN_BITS-1:0] GAIN_ONE = 17'd65536;
   localparam logic [15:0] ROUND_HALF = 16'd32768;

   // Field widths
   localparam int AXIS_W    = 3;
   localparam int REG_IDX_W = 3;
   localparam int NUM_REGS  = 6;

   // Angle axes and their measurement variance clamp
   localparam logic [AXIS_W-1:0] ANGLE_FIRST = 3'd3;
   localparam logic [AXIS_W-1:0] ANGLE_LAST  = 3'd5;
   localparam logic [31:0] Q_CLAMP_LIMIT = 32'd10 << FRAC_BITS;
   localparam logic [31:0] Q_ANGLE_ONE   = 32'd1 << FRAC_BITS;

   // Command codes
   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_STEP = 1'b1;

   // Gain divider: one quotient bit per cycle
   localparam int DIV_STEPS = GAIN_BITS;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS);

   // Queue between front and back
   localparam int QUEUE_DEPTH = 2;

   typedef enum logic [1:0] {
      KIND_LOAD,
      KIND_STEP,
      KIND_SKIP
   } kind_type;

   typedef struct packed {
      kind_type                kind;
      logic [AXIS_W-1:0]       axis;
      logic signed [31:0]      control_delta;
      logic signed [31:0]      measurement;
      logic [31:0]             meas_var;
      logic [31:0]             proc_var;
      logic signed [31:0]      init_estimate;
      logic [31:0]             init_variance;
   } item_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PRED,
      ST_DIV,
      ST_MUL,
      ST_DONE
   } back_state_type;

endpackage

@@ rtl/pose_kalman_filter_six_axis_top.sv @@
// Top level of the six-axis pose Kalman filter: front, queue, back.
//
//   channel  dir  ports                         transfer
//   req      in   req_valid/req_ready + fields  beat when valid && ready
//   rsp      out  rsp_valid/rsp_ready + fields  beat when valid && ready
//   csr      in   csr_write_enable/index/data   write when enable is high
//
// A step item goes through pop, predict, the one-bit-per-cycle gain divider,
// multiply and update in the back end; load and skipped items go from predict
// straight to update.
// Reset clears the process variances and every axis estimate and variance.
// A two-deep queue lets requests land while the back end works; the result
// register holds a finished beat while the back end moves to the next item.
module pose_kalman_filter_six_axis_top #(
   parameter int NUM_AXES = 6
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic                               req_command,
   input  logic [pkf_pkg::AXIS_W-1:0]         req_axis,
   input  logic signed [31:0]                 req_control_delta,
   input  logic signed [31:0]                 req_measurement,
   input  logic [31:0]                        req_meas_variance,
   input  logic signed [31:0]                 req_init_estimate,
   input  logic [31:0]                        req_init_variance,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [pkf_pkg::AXIS_W-1:0]         rsp_axis_out,
   output logic signed [31:0]                 rsp_estimate,
   output logic [31:0]                        rsp_variance,
   output logic [pkf_pkg::GAIN_BITS-1:0]      rsp_gain,
   input  logic                               csr_write_enable,
   input  logic [pkf_pkg::REG_IDX_W-1:0]      csr_index,
   input  logic [31:0]                        csr_write_data
);
   import pkf_pkg::*;

   logic      q_full;
   logic      q_empty;
   logic      q_push;
   logic      q_pop;
   item_type  push_item;
   item_type  pop_item;

   pkf_front #(
      .NUM_AXES (NUM_AXES)
   ) u_front (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_command       (req_command),
      .req_axis          (req_axis),
      .req_control_delta (req_control_delta),
      .req_measurement   (req_measurement),
      .req_meas_variance (req_meas_variance),
      .req_init_estimate (req_init_estimate),
      .req_init_variance (req_init_variance),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data),
      .q_full            (q_full),
      .q_push            (q_push),
      .q_item            (push_item)
   );

   pkf_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (push_item),
      .full      (q_full),
      .pop       (q_pop),
      .empty     (q_empty),
      .pop_item  (pop_item)
   );

   pkf_back #(
      .NUM_AXES (NUM_AXES)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .q_empty      (q_empty),
      .q_pop        (q_pop),
      .q_item       (pop_item),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_axis_out (rsp_axis_out),
      .rsp_estimate (rsp_estimate),
      .rsp_variance (rsp_variance),
      .rsp_gain     (rsp_gain)
   );

   // Gain never exceeds one
   a_gain_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_gain <= GAIN_ONE))
      else $error("gain above one");

   // Full gain leaves no variance
   a_full_gain_var: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_gain == GAIN_ONE)) |-> (rsp_variance == '0))
      else $error("nonzero variance at full gain");

   // Out-of-range axis gives an all-zero beat
   a_skip_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (32'(rsp_axis_out) >= 32'(NUM_AXES)))
         |-> ((rsp_estimate == '0) && (rsp_variance == '0) && (rsp_gain == '0)))
      else $error("out-of-range axis beat not zero");

   // A popped item never lands while the queue reports empty
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_empty)
      else $error("pop from empty queue");

endmodule

@@ rtl/pkf_front.sv @@
// Front end: takes request beats, holds process variances, classifies items.
module pkf_front #(
   parameter int NUM_AXES = 6
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic                               req_command,
   input  logic [pkf_pkg::AXIS_W-1:0]         req_axis,
   input  logic signed [31:0]                 req_control_delta,
   input  logic signed [31:0]                 req_measurement,
   input  logic [31:0]                        req_meas_variance,
   input  logic signed [31:0]                 req_init_estimate,
   input  logic [31:0]                        req_init_variance,
   input  logic                               csr_write_enable,
   input  logic [pkf_pkg::REG_IDX_W-1:0]      csr_index,
   input  logic [31:0]                        csr_write_data,
   input  logic                               q_full,
   output logic                               q_push,
   output pkf_pkg::item_type                  q_item
);
   import pkf_pkg::*;

   logic [31:0] proc_var_ff [NUM_REGS];
   logic        in_range;
   logic        has_reg;
   logic        is_angle;

   // Process variance registers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_REGS; i++) begin
            proc_var_ff[i] <= '0;
         end
      end else if (csr_write_enable && (csr_index < REG_IDX_W'(NUM_REGS))) begin
         proc_var_ff[csr_index] <= csr_write_data;
      end
   end

   // Handshake into the queue
   assign req_ready = !q_full;
   assign q_push    = req_valid && !q_full;

   // Classification and variance selection
   assign in_range = 32'(req_axis) < 32'(NUM_AXES);
   assign has_reg  = req_axis < AXIS_W'(NUM_REGS);
   assign is_angle = (req_axis >= ANGLE_FIRST) && (req_axis <= ANGLE_LAST);

   always_comb begin
      q_item.axis          = req_axis;
      q_item.control_delta = req_control_delta;
      q_item.measurement   = req_measurement;
      q_item.init_estimate = req_init_estimate;
      q_item.init_variance = req_init_variance;
      q_item.proc_var      = has_reg ? proc_var_ff[req_axis] : '0;
      // angle axes: a large measurement variance falls back to 1.0
      if (is_angle && (req_meas_variance >= Q_CLAMP_LIMIT)) begin
         q_item.meas_var = Q_ANGLE_ONE;
      end else begin
         q_item.meas_var = req_meas_variance;
      end
      priority if (!in_range) begin
         q_item.kind = KIND_SKIP;
      end else if (req_command == CMD_LOAD) begin
         q_item.kind = KIND_LOAD;
      end else begin
         q_item.kind = KIND_STEP;
      end
   end

endmodule

@@ rtl/pkf_queue.sv @@
// Small FIFO of classified items between front and back.
module pkf_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  pkf_pkg::item_type  push_item,
   output logic               full,
   input  logic               pop,
   output logic               empty,
   output pkf_pkg::item_type  pop_item
);
   import pkf_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   item_type           entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push;
   logic               do_pop;

   assign full     = count_ff == CNT_W'(QUEUE_DEPTH);
   assign empty    = count_ff == '0;
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_item = entry_ff[rd_ptr_ff];

   // Pointer and count updates
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

@@ rtl/pkf_back.sv @@
// Back end: per-axis state, predict, serial gain divide, update, result register.
module pkf_back #(
   parameter int NUM_AXES = 6
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 q_empty,
   output logic                                 q_pop,
   input  pkf_pkg::item_type                    q_item,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [pkf_pkg::AXIS_W-1:0]           rsp_axis_out,
   output logic signed [31:0]                   rsp_estimate,
   output logic [31:0]                          rsp_variance,
   output logic [pkf_pkg::GAIN_BITS-1:0]        rsp_gain
);
   import pkf_pkg::*;

   localparam int IDX_W = (NUM_AXES > 1) ? $clog2(NUM_AXES) : 1;
   localparam int EXT_W = IDX_W + AXIS_W;

   back_state_type         state_ff, state_in;
   item_type               item_ff;
   logic signed [31:0]     est_ff [NUM_AXES];
   logic [31:0]            var_ff [NUM_AXES];
   logic [EXT_W-1:0]       axis_ext;
   logic [IDX_W-1:0]       idx;

   // predict
   logic [32:0]            pp_sum;
   logic [31:0]            pp_in, pp_ff;
   logic [32:0]            xp_sum;
   logic signed [31:0]     xp_in, xp_ff;
   logic [32:0]            den_in, den_ff;

   // divide
   logic [DIV_CNT_W-1:0]   cnt_ff;
   logic [33:0]            rem_ff, rem_in, shifted;
   logic                   ge;
   logic [GAIN_BITS-1:0]   quo_ff;
   logic                   div_last;

   // multiply
   logic [GAIN_BITS-1:0]   gain_in, gain_ff;
   logic [32:0]            innov, innov_neg;
   logic                   neg_in, neg_ff;
   logic [31:0]            innov_mag;
   logic [GAIN_BITS-1:0]   ugain;
   logic [48:0]            xprod_in, xprod_ff;
   logic [48:0]            pprod_in, pprod_ff;

   // update
   logic [49:0]            corr_sum, p_sum;
   logic [33:0]            corr_mag;
   logic [35:0]            xp_ext, corr_ext, x_sum;
   logic signed [31:0]     x_new;
   logic [31:0]            p_new;
   logic signed [31:0]     est_out;
   logic [31:0]            var_out;
   logic [GAIN_BITS-1:0]   gain_out;
   logic                   done_fire;
   logic                   wr_state;

   // result register
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [AXIS_W-1:0]      rsp_axis_ff;
   logic signed [31:0]     rsp_est_ff;
   logic [31:0]            rsp_var_ff;
   logic [GAIN_BITS-1:0]   rsp_gain_ff;

   assign axis_ext = EXT_W'(item_ff.axis);
   assign idx      = axis_ext[IDX_W-1:0];

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (!q_empty) state_in = ST_PRED;
         ST_PRED: state_in = (item_ff.kind == KIND_STEP) ? ST_DIV : ST_DONE;
         ST_DIV:  if (div_last) state_in = ST_MUL;
         ST_MUL:  state_in = ST_DONE;
         ST_DONE: if (done_fire) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // Control outputs
   always_comb begin
      q_pop     = 1'b0;
      done_fire = 1'b0;
      unique case (state_ff)
         ST_IDLE: q_pop = !q_empty;
         ST_DONE: done_fire = !rsp_valid_ff || rsp_ready;
         default: begin
            q_pop     = 1'b0;
            done_fire = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Predict: saturated p + r and x + u, denominator p' + q
   always_comb begin
      pp_sum = {1'b0, var_ff[idx]} + {1'b0, item_ff.proc_var};
      pp_in  = pp_sum[32] ? '1 : pp_sum[31:0];
      xp_sum = {est_ff[idx][31], est_ff[idx]}
             + {item_ff.control_delta[31], item_ff.control_delta};
      if (xp_sum[32] != xp_sum[31]) begin
         xp_in = xp_sum[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
      end else begin
         xp_in = $signed(xp_sum[31:0]);
      end
      den_in = {1'b0, pp_in} + {1'b0, item_ff.meas_var};
   end

   // Restoring divide: one gain bit per cycle, MSB first
   assign shifted  = (cnt_ff == '0) ? rem_ff : {rem_ff[32:0], 1'b0};
   assign ge       = shifted >= {1'b0, den_ff};
   assign rem_in   = ge ? (shifted - {1'b0, den_ff}) : shifted;
   assign div_last = cnt_ff == DIV_CNT_W'(DIV_STEPS - 1);

   // Multiply: |y - x'| * k and (1 - k) * p'
   always_comb begin
      gain_in   = (den_ff == '0) ? '0 : quo_ff;
      innov     = {item_ff.measurement[31], item_ff.measurement} - {xp_ff[31], xp_ff};
      innov_neg = 33'd0 - innov;
      neg_in    = innov[32];
      innov_mag = neg_in ? innov_neg[31:0] : innov[31:0];
      ugain     = GAIN_ONE - gain_in;
      xprod_in  = 49'(innov_mag) * 49'(gain_in);
      pprod_in  = 49'(ugain) * 49'(pp_ff);
   end

   // Update: rounded correction, saturated estimate, rounded variance
   always_comb begin
      corr_sum = 50'(xprod_ff) + 50'(ROUND_HALF);
      corr_mag = corr_sum[49:GAIN_FRAC];
      xp_ext   = {{4{xp_ff[31]}}, xp_ff};
      corr_ext = {2'b00, corr_mag};
      x_sum    = neg_ff ? (xp_ext - corr_ext) : (xp_ext + corr_ext);
      if (x_sum[35:31] != {5{x_sum[35]}}) begin
         x_new = x_sum[35] ? 32'sh8000_0000 : 32'sh7fff_ffff;
      end else begin
         x_new = $signed(x_sum[31:0]);
      end
      p_sum = 50'(pprod_ff) + 50'(ROUND_HALF);
      p_new = p_sum[47:GAIN_FRAC];
   end

   // Result selection by item kind
   always_comb begin
      unique case (item_ff.kind)
         KIND_LOAD: begin
            est_out  = item_ff.init_estimate;
            var_out  = item_ff.init_variance;
            gain_out = '0;
         end
         KIND_STEP: begin
            est_out  = x_new;
            var_out  = p_new;
            gain_out = gain_ff;
         end
         default: begin
            est_out  = '0;
            var_out  = '0;
            gain_out = '0;
         end
      endcase
   end

   assign wr_state = done_fire && (item_ff.kind != KIND_SKIP);

   // Datapath registers
   always_ff @(posedge clock) begin
      if (q_pop) begin
         item_ff <= q_item;
      end
      if (state_ff == ST_PRED) begin
         pp_ff  <= pp_in;
         xp_ff  <= xp_in;
         den_ff <= den_in;
         rem_ff <= {2'b00, pp_in};
         cnt_ff <= '0;
         quo_ff <= '0;
      end
      if (state_ff == ST_DIV) begin
         rem_ff <= rem_in;
         cnt_ff <= cnt_ff + 1'b1;
         quo_ff <= {quo_ff[GAIN_BITS-2:0], ge};
      end
      if (state_ff == ST_MUL) begin
         gain_ff  <= gain_in;
         neg_ff   <= neg_in;
         xprod_ff <= xprod_in;
         pprod_ff <= pprod_in;
      end
   end

   // Per-axis state
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_AXES; i++) begin
            est_ff[i] <= '0;
            var_ff[i] <= '0;
         end
      end else if (wr_state) begin
         est_ff[idx] <= est_out;
         var_ff[idx] <= var_out;
      end
   end

   // Result register
   assign rsp_valid_in = done_fire ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (done_fire) begin
         rsp_axis_ff <= item_ff.axis;
         rsp_est_ff  <= est_out;
         rsp_var_ff  <= var_out;
         rsp_gain_ff <= gain_out;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_axis_out = rsp_axis_ff;
   assign rsp_estimate = rsp_est_ff;
   assign rsp_variance = rsp_var_ff;
   assign rsp_gain     = rsp_gain_ff;

endmodule
